// ----- rtl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the stream error metrics block.
// ----------------------------------------------------------------------------
`default_nettype none
package sem_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CountW  = 25;
	localparam int unsigned SumW    = 58;
	localparam int unsigned RelW    = 32;

	// configuration register indexes
	localparam logic CfgMaskEnable   = 1'b0;
	localparam logic CfgMissingValue = 1'b1;

	// closed run summary handed from the accumulator to the finisher
	typedef struct packed {
		logic signed [SampleW-1:0] run_min;
		logic signed [SampleW-1:0] run_max;
		logic [SampleW-1:0]        max_err;
		logic [SumW-1:0]           sq_sum;
		logic [CountW-1:0]         count;
		logic                      seen;
	} run_sum_t;

	typedef struct packed {
		logic signed [SampleW-1:0] range_min;
		logic signed [SampleW-1:0] range_max;
		logic [SampleW-1:0]        max_abs_error;
		logic [SampleW-1:0]        rms_error;
		logic [RelW-1:0]           rel_max_error;
		logic [RelW-1:0]           norm_rms_error;
		logic [CountW-1:0]         valid_count;
		logic                      none_valid;
	} result_t;

	typedef struct packed {
		logic signed [SampleW-1:0] original_sample;
		logic signed [SampleW-1:0] recon_sample;
		logic                      last_pair;
	} pair_t;

endpackage
`default_nettype wire

// ----- rtl/sem_stream_if.sv -----
// ----------------------------------------------------------------------------
// sem_stream_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface sem_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sem_accum.sv -----
// ----------------------------------------------------------------------------
// sem_accum
// Front part: masks pairs, accumulates run statistics, closes runs.
// ----------------------------------------------------------------------------
`default_nettype none
module sem_accum
	import sem_pkg::*;
#(
	parameter int unsigned MAX_PAIRS = 16777216
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      mask_enable,
	input  wire logic signed [SampleW-1:0] missing_value,
	sem_stream_if.sink                     in_pair,
	output run_sum_t                       run_sum,
	output logic                           run_push,
	input  wire logic                      run_full
);

	logic signed [SampleW-1:0] min_q, max_q;
	logic [SampleW-1:0]        err_q;
	logic [SumW-1:0]           sum_q;
	logic [CountW-1:0]         cnt_q;
	logic                      seen_q;

	logic                      acc;
	logic                      take;
	logic signed [SampleW:0]   diff;
	logic [SampleW-1:0]        ad;
	logic [2*SampleW-1:0]      sq;
	run_sum_t                  nxt;

	// only stall when a run must close and the queue is full
	assign in_pair.ready = !(run_full && in_pair.data.last_pair);
	assign take = in_pair.valid && in_pair.ready;

	// classify and compute the updated statistics
	always_comb begin
		acc  = !(mask_enable && (in_pair.data.recon_sample == missing_value))
			&& (cnt_q < CountW'(MAX_PAIRS));
		diff = (SampleW+1)'(in_pair.data.original_sample)
			- (SampleW+1)'(in_pair.data.recon_sample);
		ad   = diff[SampleW] ? SampleW'(-diff) : SampleW'(diff);
		sq   = ad * ad;
		nxt.run_min = min_q;
		nxt.run_max = max_q;
		nxt.max_err = err_q;
		nxt.sq_sum  = sum_q;
		nxt.count   = cnt_q;
		nxt.seen    = seen_q;
		if (acc) begin
			if (!seen_q || in_pair.data.original_sample < min_q)
				nxt.run_min = in_pair.data.original_sample;
			if (!seen_q || in_pair.data.original_sample > max_q)
				nxt.run_max = in_pair.data.original_sample;
			if (ad > err_q) nxt.max_err = ad;
			nxt.sq_sum = sum_q + SumW'(sq);
			nxt.count  = cnt_q + 1'b1;
			nxt.seen   = 1'b1;
		end
	end

	assign run_sum  = nxt;
	assign run_push = take && in_pair.data.last_pair;

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0; max_q <= '0; err_q <= '0;
			sum_q <= '0; cnt_q <= '0; seen_q <= 1'b0;
		end else if (take) begin
			if (in_pair.data.last_pair) begin
				min_q <= '0; max_q <= '0; err_q <= '0;
				sum_q <= '0; cnt_q <= '0; seen_q <= 1'b0;
			end else begin
				min_q <= nxt.run_min; max_q <= nxt.run_max; err_q <= nxt.max_err;
				sum_q <= nxt.sq_sum; cnt_q <= nxt.count; seen_q <= nxt.seen;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sem_queue.sv -----
// ----------------------------------------------------------------------------
// sem_queue
// Two-entry queue of closed run summaries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module sem_queue
	import sem_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire run_sum_t wr_data,
	input  wire logic     push,
	output logic          full,
	output run_sum_t      rd_data,
	output logic          not_empty,
	input  wire logic     pop
);

	run_sum_t  mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign rd_data   = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sem_finish.sv -----
// ----------------------------------------------------------------------------
// sem_finish
// Back part: mean square, square root, Q16.16 ratios, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sem_finish
	import sem_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire run_sum_t run_sum,
	input  wire logic     run_avail,
	output logic          run_pop,
	sem_stream_if.source  res
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_RMAX = 6'b001000,
		ST_RRMS = 6'b010000,
		ST_OUT  = 6'b100000
	} fin_state_t;

	// divisor holds either a pair count or a range
	localparam int unsigned     DenW      = CountW;
	localparam logic [5:0]      MeanLast  = 6'(SumW - 1);
	localparam logic [5:0]      RatioLast = 6'(RelW - 1);
	localparam logic [SumW-1:0] SqrtTop   = SumW'(1) << (SumW - 2);

	fin_state_t         st_q;
	run_sum_t           rs_q;
	logic [5:0]         step_q;
	// shared restoring divider, quotient bits shift in behind the dividend
	logic [SumW-1:0]    dnum_q;
	logic [DenW-1:0]    drem_q;
	logic [DenW-1:0]    dden_q;
	// square root
	logic [SumW-1:0]    sx_q;
	logic [SumW-1:0]    sroot_q;
	logic [SumW-1:0]    sbit_q;
	logic [SampleW-1:0] rms_q;
	logic [RelW-1:0]    rel1_q;
	logic [SampleW:0]   range;
	logic               zero_range;
	logic [DenW:0]      rtry;
	logic               dge;
	logic [DenW-1:0]    drem_nx;
	logic [SumW-1:0]    dnum_nx;
	logic [SumW-1:0]    stry;
	logic               sge;
	logic [SumW-1:0]    sroot_nx;
	result_t            out_q;
	logic               ovalid_q;
	logic               out_load;

	assign range      = (SampleW+1)'(rs_q.run_max) - (SampleW+1)'(rs_q.run_min);
	assign zero_range = (range == '0);

	// one divider step
	assign rtry    = {drem_q, dnum_q[SumW-1]};
	assign dge     = rtry >= {1'b0, dden_q};
	assign drem_nx = dge ? DenW'(rtry - {1'b0, dden_q}) : DenW'(rtry);
	assign dnum_nx = {dnum_q[SumW-2:0], dge};

	// one square root step
	assign stry     = sroot_q + sbit_q;
	assign sge      = sx_q >= stry;
	assign sroot_nx = sge ? (sroot_q >> 1) + sbit_q : sroot_q >> 1;

	assign run_pop   = (st_q == ST_IDLE) && run_avail;
	assign out_load  = (st_q == ST_OUT) && (!ovalid_q || res.ready);
	assign res.valid = ovalid_q;
	assign res.data  = out_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: if (run_avail) st_q <= ST_DIV;
				ST_DIV:  if (step_q == MeanLast) st_q <= ST_SQRT;
				ST_SQRT: if (sbit_q == SumW'(1)) st_q <= ST_RMAX;
				ST_RMAX: if (step_q == RatioLast) st_q <= ST_RRMS;
				ST_RRMS: if (step_q == RatioLast) st_q <= ST_OUT;
				ST_OUT:  if (out_load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// divide, root and ratio datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				rs_q   <= run_sum;
				dnum_q <= run_sum.sq_sum;
				drem_q <= '0;
				dden_q <= run_sum.count;
				step_q <= '0;
			end
			ST_DIV: begin
				// one quotient bit per cycle
				dnum_q  <= dnum_nx;
				drem_q  <= drem_nx;
				step_q  <= step_q + 1'b1;
				sx_q    <= (rs_q.count == '0) ? '0 : dnum_nx;
				sroot_q <= '0;
				sbit_q  <= SqrtTop;
			end
			ST_SQRT: begin
				// one root bit per cycle
				if (sge) sx_q <= sx_q - stry;
				sroot_q <= sroot_nx;
				sbit_q  <= sbit_q >> 2;
				rms_q   <= sroot_nx[SampleW-1:0];
				// set up max error over range
				dnum_q  <= {rs_q.max_err, {(SumW-SampleW){1'b0}}};
				drem_q  <= '0;
				dden_q  <= DenW'(range);
				step_q  <= '0;
			end
			ST_RMAX: begin
				if (step_q == RatioLast) begin
					rel1_q <= dnum_nx[RelW-1:0];
					// set up rms over range
					dnum_q <= {rms_q, {(SumW-SampleW){1'b0}}};
					drem_q <= '0;
					step_q <= '0;
				end else begin
					dnum_q <= dnum_nx;
					drem_q <= drem_nx;
					step_q <= step_q + 1'b1;
				end
			end
			ST_RRMS: begin
				dnum_q <= dnum_nx;
				drem_q <= drem_nx;
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.range_min      <= rs_q.run_min;
			out_q.range_max      <= rs_q.run_max;
			out_q.max_abs_error  <= rs_q.max_err;
			out_q.rms_error      <= rms_q;
			out_q.rel_max_error  <= zero_range ? '0 : rel1_q;
			out_q.norm_rms_error <= zero_range ? '0 : dnum_q[RelW-1:0];
			out_q.valid_count    <= rs_q.count;
			out_q.none_valid     <= !rs_q.seen;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/stream_error_metrics.sv -----
// Result path: the accepted last pair of a run closes it; the back end pops its
// summary, then runs a 58-step mean divide, a 29-step square root, two 32-step
// ratio divides and one output load.
// Throughput: one pair per cycle; the back end finishes one run at a time and
// two closed runs may wait in the queue before the input stalls on a last pair.
// Reset: arst_n clears accumulators, registers, queue and state machine.
`default_nettype none
module stream_error_metrics
	import sem_pkg::*;
#(
	parameter int unsigned MAX_PAIRS = 16777216
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [SampleW-1:0]        cfg_data,
	sem_stream_if.sink                     in_pair,
	sem_stream_if.source                   result
);

	logic                      mask_q;
	logic signed [SampleW-1:0] missing_q;
	run_sum_t                  push_d, pop_d;
	logic                      push, full, avail, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 1'b0; missing_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgMaskEnable:   mask_q <= cfg_data[0];
				CfgMissingValue: missing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sem_accum #(.MAX_PAIRS(MAX_PAIRS)) u_accum (
		.clk, .arst_n, .mask_enable(mask_q), .missing_value(missing_q),
		.in_pair, .run_sum(push_d), .run_push(push), .run_full(full)
	);

	sem_queue u_queue (
		.clk, .arst_n, .wr_data(push_d), .push, .full,
		.rd_data(pop_d), .not_empty(avail), .pop
	);

	sem_finish u_finish (
		.clk, .arst_n, .run_sum(pop_d), .run_avail(avail), .run_pop(pop),
		.res(result)
	);

endmodule
`default_nettype wire
